FILE: hdl/rre_pkg.sv
// ----------------------------------------------------------------------------
// rre_pkg
// Shared types and constants of the row run extractor: result item layout,
// result kinds, field widths and default limits.
// ----------------------------------------------------------------------------
package rre_pkg;

    localparam int MAX_WIDTH_DEF = 512;
    localparam int MAX_RUNS_DEF  = 16;

    localparam int PIXEL_W      = 8;
    localparam int RUN_START_W  = 9;
    localparam int RUN_END_W    = 10;
    localparam int RUN_COUNT_W  = 5;
    localparam int SPAN_W       = 10;

    // result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_IW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        KIND_RUN     = 1'b0,
        KIND_SUMMARY = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic [RUN_START_W-1:0]   run_start;
        logic [RUN_END_W-1:0]     run_end;
        logic [RUN_COUNT_W-1:0]   run_count;
        logic                     overflow;
        logic [SPAN_W-1:0]        span_start;
        logic [SPAN_W-1:0]        span_end;
        logic                     last;
    } t_result;

    // results produced by one pixel, first is always taken before second
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_scan_out;

endpackage

FILE: hdl/row_run_extractor.sv
// ----------------------------------------------------------------------------
// row_run_extractor
// Row run extraction: reports up to MAX_RUNS runs of non-empty pixels of a
// row, each as a half-open interval, and a summary item at the end of the row.
// ----------------------------------------------------------------------------
// Takes one pixel item per clock while o_stall is low. Each pixel sits in the
// input register while the run logic works out its results, which go into a
// four-entry result queue; the head of that queue drives the output ports.
// A pixel gives zero, one or two result items (a run closed on the row's last
// pixel gives the run, then the summary), and the output side moves one item
// per cycle while i_stall is low, so rows that close runs on their last pixel
// can fill the queue and stall the input. Write empty_value only while idle.
module row_run_extractor #(
    parameter int MAX_WIDTH = rre_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RUNS  = rre_pkg::MAX_RUNS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rre_pkg::PIXEL_W-1:0]      i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [rre_pkg::PIXEL_W-1:0]      i_pixel,
    input  logic                             i_row_end,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_kind,
    output logic [rre_pkg::RUN_START_W-1:0]  o_run_start,
    output logic [rre_pkg::RUN_END_W-1:0]    o_run_end,
    output logic [rre_pkg::RUN_COUNT_W-1:0]  o_run_count,
    output logic                             o_overflow,
    output logic [rre_pkg::SPAN_W-1:0]       o_span_start,
    output logic [rre_pkg::SPAN_W-1:0]       o_span_end,
    output logic                             o_last
);

    localparam int QD  = rre_pkg::QUEUE_DEPTH;
    localparam int QIW = rre_pkg::QUEUE_IW;
    localparam int QCW = rre_pkg::QUEUE_CW;

    logic [rre_pkg::PIXEL_W-1:0] r_empty_value;
    logic                        r_in_valid;
    logic [rre_pkg::PIXEL_W-1:0] r_pixel;
    logic                        r_row_end;

    rre_pkg::t_result  r_q [QD];
    rre_pkg::t_result  n_q [QD];
    logic [QCW-1:0]    r_cnt, n_cnt;

    rre_pkg::t_scan_out scan;
    logic               adv;
    logic               pop;
    logic               in_acc;

    rre_scan #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_RUNS  (MAX_RUNS)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_pixel       (r_pixel),
        .i_row_end     (r_row_end),
        .i_empty_value (r_empty_value),
        .o_scan        (scan)
    );

    // room for two results whatever the output side does
    assign adv     = r_in_valid && (r_cnt <= QCW'(QD - 2));
    assign o_stall = r_in_valid && !adv;
    assign in_acc  = i_valid && !o_stall;
    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && !i_stall;

    always_comb begin
        logic [QCW-1:0] mid_cnt;
        logic [QIW-1:0] idx0;
        logic [QIW-1:0] idx1;

        n_q     = r_q;
        mid_cnt = r_cnt;
        if (pop) begin
            for (int i = 0; i < QD - 1; i++) begin
                n_q[i] = r_q[i + 1];
            end
            mid_cnt = r_cnt - QCW'(1);
        end
        idx0  = mid_cnt[QIW-1:0];
        idx1  = idx0 + QIW'(1);
        n_cnt = mid_cnt;
        if (adv) begin
            if (scan.count != 2'd0) begin
                n_q[idx0] = scan.first;
            end
            if (scan.count == 2'd2) begin
                n_q[idx1] = scan.second;
            end
            n_cnt = mid_cnt + QCW'(scan.count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty_value <= '0;
            r_in_valid    <= 1'b0;
            r_cnt         <= '0;
        end else begin
            if (i_cfg_we) begin
                r_empty_value <= i_cfg_data;
            end
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pixel   <= i_pixel;
            r_row_end <= i_row_end;
        end
        r_q <= n_q;
    end

    assign o_kind       = r_q[0].kind;
    assign o_run_start  = r_q[0].run_start;
    assign o_run_end    = r_q[0].run_end;
    assign o_run_count  = r_q[0].run_count;
    assign o_overflow   = r_q[0].overflow;
    assign o_span_start = r_q[0].span_start;
    assign o_span_end   = r_q[0].span_end;
    assign o_last       = r_q[0].last;

    // queue never overfills
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCW'(QD))
        else $error("result queue over depth");

    // a summary item always closes its pixel's results
    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == rre_pkg::KIND_SUMMARY) |-> o_last)
        else $error("summary item without last");

    // a run item is never empty (checked while MAX_WIDTH is at most 512)
    a_run_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == rre_pkg::KIND_RUN) && (MAX_WIDTH <= 512)
        |-> ({1'b0, o_run_start} < o_run_end))
        else $error("run item with empty interval");

endmodule

FILE: hdl/rre_scan.sv
// ----------------------------------------------------------------------------
// rre_scan
// Per-pixel row state and run detection. Computes the results of one pixel
// and updates the row state when the pixel is processed.
// ----------------------------------------------------------------------------
module rre_scan #(
    parameter int MAX_WIDTH = rre_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RUNS  = rre_pkg::MAX_RUNS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic [rre_pkg::PIXEL_W-1:0]  i_pixel,
    input  logic                         i_row_end,
    input  logic [rre_pkg::PIXEL_W-1:0]  i_empty_value,
    output rre_pkg::t_scan_out           o_scan
);

    localparam int XW = $clog2(MAX_WIDTH + 1);
    localparam int CW = $clog2(MAX_RUNS + 1);

    logic [XW-1:0] r_x_pos, n_x_pos;
    logic          r_in_run, n_in_run;
    logic [XW-1:0] r_cur_start, n_cur_start;
    logic [CW-1:0] r_runs, n_runs;
    logic          r_ovf, n_ovf;
    logic [XW-1:0] r_span_low, n_span_low;
    logic [XW-1:0] r_span_high, n_span_high;
    logic          r_any, n_any;

    logic          in_range;
    logic          filled;
    logic          closing;
    logic          emit_run;
    logic [XW-1:0] x_plus1;
    logic [XW-1:0] run_end;

    rre_pkg::t_result run_res;
    rre_pkg::t_result sum_res;

    assign in_range = r_x_pos < XW'(MAX_WIDTH);
    assign filled   = in_range && (i_pixel != i_empty_value);
    assign x_plus1  = r_x_pos + XW'(1);

    always_comb begin
        n_x_pos     = r_x_pos;
        n_in_run    = r_in_run;
        n_cur_start = r_cur_start;
        n_runs      = r_runs;
        n_ovf       = r_ovf;
        n_span_low  = r_span_low;
        n_span_high = r_span_high;
        n_any       = r_any;

        if (filled) begin
            if (!r_any) begin
                n_span_low = r_x_pos;
                n_any      = 1'b1;
            end
            n_span_high = x_plus1;
            if (!r_in_run) begin
                if (r_runs >= CW'(MAX_RUNS)) begin
                    n_ovf = 1'b1;
                end
                n_in_run    = 1'b1;
                n_cur_start = r_x_pos;
            end
        end

        // a run closes on an empty pixel, or on the row's last pixel
        closing  = (!filled && r_in_run) || (i_row_end && filled);
        emit_run = closing && !n_ovf && (r_runs < CW'(MAX_RUNS));
        run_end  = filled ? x_plus1 : r_x_pos;
        if (closing) begin
            n_in_run = 1'b0;
        end
        if (emit_run) begin
            n_runs = r_runs + CW'(1);
        end
        if (in_range) begin
            n_x_pos = x_plus1;
        end

        run_res            = '0;
        run_res.kind       = rre_pkg::KIND_RUN;
        run_res.run_start  = rre_pkg::RUN_START_W'(n_cur_start);
        run_res.run_end    = rre_pkg::RUN_END_W'(run_end);
        run_res.last       = !i_row_end;

        sum_res            = '0;
        sum_res.kind       = rre_pkg::KIND_SUMMARY;
        sum_res.run_count  = rre_pkg::RUN_COUNT_W'(n_runs);
        sum_res.overflow   = n_ovf;
        sum_res.span_start = n_any ? rre_pkg::SPAN_W'(n_span_low)
                                   : rre_pkg::SPAN_W'(n_x_pos);
        sum_res.span_end   = n_any ? rre_pkg::SPAN_W'(n_span_high) : '0;
        sum_res.last       = 1'b1;

        o_scan.count  = {1'b0, emit_run} + {1'b0, i_row_end};
        o_scan.first  = emit_run ? run_res : sum_res;
        o_scan.second = sum_res;

        if (i_row_end) begin
            n_x_pos     = '0;
            n_in_run    = 1'b0;
            n_cur_start = '0;
            n_runs      = '0;
            n_ovf       = 1'b0;
            n_span_low  = '0;
            n_span_high = '0;
            n_any       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_pos     <= '0;
            r_in_run    <= 1'b0;
            r_cur_start <= '0;
            r_runs      <= '0;
            r_ovf       <= 1'b0;
            r_span_low  <= '0;
            r_span_high <= '0;
            r_any       <= 1'b0;
        end else if (i_adv) begin
            r_x_pos     <= n_x_pos;
            r_in_run    <= n_in_run;
            r_cur_start <= n_cur_start;
            r_runs      <= n_runs;
            r_ovf       <= n_ovf;
            r_span_low  <= n_span_low;
            r_span_high <= n_span_high;
            r_any       <= n_any;
        end
    end

endmodule
